FILE: hw/rtl/rgbpk_pkg.sv
// Package for the RGBA pixel packer: format codes, configuration and
// queue entry types, and shared sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rgbpk_pkg;

  localparam logic [2:0] FMT_RGB332   = 3'd0;
  localparam logic [2:0] FMT_RGB565   = 3'd1;
  localparam logic [2:0] FMT_ARGB8888 = 3'd2;
  localparam logic [2:0] FMT_ALPHA1   = 3'd3;
  localparam logic [2:0] FMT_ALPHA2   = 3'd4;
  localparam logic [2:0] FMT_ALPHA4   = 3'd5;
  localparam logic [2:0] FMT_ALPHA8   = 3'd6;

  // register indexes on the APB port
  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [1:0] REG_KEEP_ALPHA   = 2'd1;
  localparam logic [1:0] REG_SWAP_BYTES   = 2'd2;
  localparam logic [1:0] REG_ROW_PIXELS   = 2'd3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [2:0]  pixel_format;
    logic        keep_alpha;
    logic        swap_bytes;
    logic [10:0] row_pixels;
  } cfg_t;

  // bytes caused by one pixel, sent from index 0 up; count is 0..4
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
  } entry_t;

  // queue handshake between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rgbpk_front.sv
// Front end: accepts pixels, converts them into up to four bytes and tracks
// the row column and the alpha packing state. Uses rgbpk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rgbpk_front import rgbpk_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  input  wire logic [7:0] alpha,
  input  wire q_status_t  q_status,
  output logic            push,
  output entry_t          push_entry
);

  logic [10:0] column_count, column_count_next;
  logic [7:0]  pack_byte, pack_byte_next;
  logic [2:0]  pack_bits_used, pack_bits_used_next;

  logic        accept;
  logic [11:0] row_len;
  logic        row_end;
  logic [1:0]  bits_log;
  logic [3:0]  bits;
  logic [7:0]  sample;
  logic        overflow;
  logic [7:0]  base_byte;
  logic [3:0]  base_used;
  logic [3:0]  shift;
  logic [7:0]  new_byte;
  logic [3:0]  new_used;
  logic [15:0] w565;
  entry_t      ent;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // a row length of zero stands for 2048 pixels
  assign row_len = (cfg.row_pixels == 11'd0) ? 12'd2048 : {1'b0, cfg.row_pixels};
  assign row_end = ({1'b0, column_count} + 12'd1) >= row_len;

  assign bits_log = 2'(cfg.pixel_format - FMT_ALPHA1);
  assign bits     = 4'd1 << bits_log;
  assign sample   = alpha >> (4'd8 - bits);
  assign overflow = ({1'b0, pack_bits_used} + bits) > 4'd8;
  assign base_byte = overflow ? 8'd0 : pack_byte;
  assign base_used = overflow ? 4'd0 : {1'b0, pack_bits_used};
  assign shift     = 4'd8 - bits - base_used;
  assign new_byte  = base_byte | (sample << shift);
  assign new_used  = base_used + bits;

  assign w565 = {red[7:3], green[7:2], blue[7:3]};

  always_comb begin
    ent = '0;
    pack_byte_next      = pack_byte;
    pack_bits_used_next = pack_bits_used;
    case (cfg.pixel_format) inside
      FMT_RGB332: begin
        ent.bytes[0] = {red[7:5], green[7:5], blue[7:6]};
        ent.bytes[1] = alpha;
        ent.count    = cfg.keep_alpha ? 3'd2 : 3'd1;
      end
      FMT_RGB565: begin
        ent.bytes[0] = cfg.swap_bytes ? w565[15:8] : w565[7:0];
        ent.bytes[1] = cfg.swap_bytes ? w565[7:0] : w565[15:8];
        ent.bytes[2] = alpha;
        ent.count    = cfg.keep_alpha ? 3'd3 : 3'd2;
      end
      FMT_ARGB8888: begin
        ent.bytes[0] = blue;
        ent.bytes[1] = green;
        ent.bytes[2] = red;
        ent.bytes[3] = cfg.keep_alpha ? alpha : 8'hFF;
        ent.count    = 3'd4;
      end
      FMT_ALPHA1, FMT_ALPHA2, FMT_ALPHA4, FMT_ALPHA8: begin
        // a sample that does not fit first pushes out the partial byte
        if (overflow) begin
          ent.bytes[0] = pack_byte;
          ent.bytes[1] = new_byte;
        end else begin
          ent.bytes[0] = new_byte;
        end
        if (new_used >= 4'd8 || row_end) begin
          ent.count           = overflow ? 3'd2 : 3'd1;
          pack_byte_next      = 8'd0;
          pack_bits_used_next = 3'd0;
        end else begin
          ent.count           = overflow ? 3'd1 : 3'd0;
          pack_byte_next      = new_byte;
          pack_bits_used_next = new_used[2:0];
        end
      end
      default: ent.count = 3'd0;
    endcase
    if (row_end) begin
      column_count_next   = 11'd0;
      pack_byte_next      = 8'd0;
      pack_bits_used_next = 3'd0;
    end else begin
      column_count_next = column_count + 11'd1;
    end
  end

  assign push       = accept && (ent.count != 3'd0);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= '0;
      pack_byte      <= '0;
      pack_bits_used <= '0;
    end else if (accept) begin
      column_count   <= column_count_next;
      pack_byte      <= pack_byte_next;
      pack_bits_used <= pack_bits_used_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rgbpk_queue.sv
// Short FIFO of per-pixel byte groups between front and back ends.
// Uses rgbpk_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none
module rgbpk_queue import rgbpk_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output q_status_t   status
);

  entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QPTR_W:0]     fill;

  assign head         = mem[rd_ptr];
  assign status.full  = (fill == (QPTR_W+1)'(QDEPTH));
  assign status.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rgbpk_back.sv
// Back end: holds one byte group and sends its bytes one per cycle while
// out_ready is high, flagging the last byte of each pixel. Uses rgbpk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rgbpk_back import rgbpk_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire entry_t     head,
  input  wire q_status_t  q_status,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            last_of_run
);

  entry_t     work;
  logic       work_valid;
  logic [1:0] idx;
  logic       load;

  assign out_valid   = work_valid;
  assign out_byte    = work.bytes[idx];
  assign last_of_run = ({1'b0, idx} + 3'd1) == work.count;

  // reload when empty or when the last byte leaves this cycle
  assign load = !work_valid || (out_ready && last_of_run);
  assign pop  = load && !q_status.empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      work <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      idx        <= '0;
    end else if (load) begin
      work_valid <= !q_status.empty;
      idx        <= '0;
    end else if (out_ready) begin
      idx <= idx + 2'd1;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rgba_pixel_format_packer.sv
// RGBA8888 pixel packer top level: APB register file, front end, queue and
// back end. Uses rgbpk_pkg, rgbpk_front, rgbpk_queue and rgbpk_back.
`timescale 1ns / 1ps
`default_nettype none
// Takes one RGBA8888 pixel per transaction and emits the converted stream one
// byte per transaction, last_of_run marking the final byte of each pixel. The
// byte serializer sends one byte per cycle while out_ready is high, and the
// input takes at most one pixel per cycle, stalling on a full queue. A pixel
// yields 1-2 bytes for rgb332, 2-3 for rgb565, 4 for argb8888 and 0-2 for
// the alpha formats. A four-entry queue between conversion and serializer
// lets pixels keep arriving while bytes drain. Registers (APB, 4-byte spacing):
// pixel_format, keep_alpha, swap_bytes, row_pixels; write them only while idle.
module rgba_pixel_format_packer import rgbpk_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  input  wire logic [7:0]  alpha,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             last_of_run
);

  cfg_t      cfg;
  q_status_t q_status;
  logic      push;
  logic      pop;
  entry_t    push_entry;
  entry_t    head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format <= FMT_RGB332;
      cfg.keep_alpha   <= 1'b0;
      cfg.swap_bytes   <= 1'b0;
      cfg.row_pixels   <= 11'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_PIXEL_FORMAT: cfg.pixel_format <= pwdata[2:0];
        REG_KEEP_ALPHA:   cfg.keep_alpha   <= pwdata[0];
        REG_SWAP_BYTES:   cfg.swap_bytes   <= pwdata[0];
        REG_ROW_PIXELS:   cfg.row_pixels   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PIXEL_FORMAT: prdata = {29'd0, cfg.pixel_format};
      REG_KEEP_ALPHA:   prdata = {31'd0, cfg.keep_alpha};
      REG_SWAP_BYTES:   prdata = {31'd0, cfg.swap_bytes};
      REG_ROW_PIXELS:   prdata = {21'd0, cfg.row_pixels};
      default:          prdata = 32'd0;
    endcase
  end

  rgbpk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  rgbpk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  rgbpk_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Testbench for rgba_pixel_format_packer: streams RGBA pixels through every
// format and checks each output byte against an in-bench conversion model.
// Depends on rgbpk_pkg and the packer RTL.
`timescale 1ns / 1ps
module testbench;
  import rgbpk_pkg::*;

  localparam logic [2:0] FMT_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PIXELS = 245;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  red = '0;
  logic [7:0]  green = '0;
  logic [7:0]  blue = '0;
  logic [7:0]  alpha = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_run;

  rgba_pixel_format_packer dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .red(red), .green(green), .blue(blue), .alpha(alpha),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .last_of_run(last_of_run)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // pixels waiting for the driver, and bytes the conversion model predicts
  rgba_t     pixel_q[$];
  out_beat_t want_bytes[$];

  int pushed_cnt = 0;
  int accepted_cnt = 0;
  int bytes_seen = 0;
  int mismatch_cnt = 0;
  int phase_cnt = 0;

  // model copy of registers and packing state
  logic [2:0]  m_fmt = FMT_RGB332;
  logic        m_keep = 1'b0;
  logic        m_swap = 1'b0;
  logic [10:0] m_row = 11'd1;
  int          col_pos = 0;
  logic [7:0]  alpha_acc = '0;
  int          alpha_fill = 0;

  task automatic convert_pixel(input rgba_t px);
    logic [7:0]  beats[$];
    logic [15:0] w565;
    logic [7:0]  sample;
    int          row_len;
    int          bits;
    bit          row_end;
    row_len = (m_row == 11'd0) ? 2048 : int'(m_row);
    row_end = (col_pos + 1 >= row_len);
    w565 = {px.r[7:3], px.g[7:2], px.b[7:3]};
    case (m_fmt)
      FMT_RGB332: begin
        beats.push_back({px.r[7:5], px.g[7:5], px.b[7:6]});
        if (m_keep) beats.push_back(px.a);
      end
      FMT_RGB565: begin
        if (m_swap) begin
          beats.push_back(w565[15:8]);
          beats.push_back(w565[7:0]);
        end else begin
          beats.push_back(w565[7:0]);
          beats.push_back(w565[15:8]);
        end
        if (m_keep) beats.push_back(px.a);
      end
      FMT_ARGB8888: begin
        beats.push_back(px.b);
        beats.push_back(px.g);
        beats.push_back(px.r);
        beats.push_back(m_keep ? px.a : 8'hFF);
      end
      FMT_ALPHA1, FMT_ALPHA2, FMT_ALPHA4, FMT_ALPHA8: begin
        bits = 1 << (m_fmt - FMT_ALPHA1);
        sample = px.a >> (8 - bits);
        // sample does not fit: flush the partial byte first
        if (alpha_fill + bits > 8) begin
          beats.push_back(alpha_acc);
          alpha_acc = '0;
          alpha_fill = 0;
        end
        alpha_acc = alpha_acc | 8'(sample << (8 - bits - alpha_fill));
        alpha_fill += bits;
        if (alpha_fill >= 8 || row_end) begin
          beats.push_back(alpha_acc);
          alpha_acc = '0;
          alpha_fill = 0;
        end
      end
      default: ;
    endcase
    if (row_end) begin
      col_pos = 0;
      alpha_acc = '0;
      alpha_fill = 0;
    end else begin
      col_pos++;
    end
    foreach (beats[i])
      want_bytes.push_back('{data: beats[i], last: (i == beats.size() - 1)});
  endtask

  // monitor: register writes, accepted pixels and accepted bytes
  out_beat_t head_beat;

  always @(posedge clk) begin
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_PIXEL_FORMAT: m_fmt = pwdata[2:0];
          REG_KEEP_ALPHA:   m_keep = pwdata[0];
          REG_SWAP_BYTES:   m_swap = pwdata[0];
          REG_ROW_PIXELS:   m_row = pwdata[10:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        convert_pixel({red, green, blue, alpha});
        accepted_cnt++;
      end
      if (out_valid && out_ready) begin
        bytes_seen++;
        if (want_bytes.size() == 0) begin
          $error("unexpected transaction: out_byte %02h last_of_run %0b", out_byte,
                 last_of_run);
          mismatch_cnt++;
        end else begin
          head_beat = want_bytes.pop_front();
          if (out_byte !== head_beat.data) begin
            $error("out_byte: expected %02h, got %02h", head_beat.data, out_byte);
            mismatch_cnt++;
          end
          if (last_of_run !== head_beat.last) begin
            $error("last_of_run: expected %0b, got %0b", head_beat.last, last_of_run);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // driver: bursts of pixels with random gaps
  rgba_t cur_px;
  int    burst_left = 0;
  int    gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pixel_q.size() > 0) begin
        cur_px = pixel_q.pop_front();
        {red, green, blue, alpha} <= cur_px;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: rotating stall pattern, reselected each time pat_age wraps, plus one long hold
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_left = 0;
  logic [15:0] ready_pat = '1;
  int          pat_age = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_taken <= 1'b0;
      hold_left <= 0;
      ready_pat <= '1;
      pat_age <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ready_pat[0];
      if (pat_age == 31) begin
        pat_age <= 0;
        case ($urandom_range(0, 3))
          0: ready_pat <= '1;
          1: ready_pat <= 16'($urandom());
          2: ready_pat <= 16'($urandom() & $urandom());
          default: ready_pat <= 16'($urandom() | $urandom());
        endcase
      end else begin
        pat_age <= pat_age + 1;
        ready_pat <= {ready_pat[0], ready_pat[15:1]};
      end
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait until every pixel is in and every byte is out, then let the pipe empty
  task automatic settle();
    while (accepted_cnt != pushed_cnt || want_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_cfg(input logic [2:0] fmt, input logic keep, input logic swap,
                         input logic [10:0] row);
    settle();
    apb_write(REG_PIXEL_FORMAT, 32'(fmt));
    apb_write(REG_KEEP_ALPHA, 32'(keep));
    apb_write(REG_SWAP_BYTES, 32'(swap));
    apb_write(REG_ROW_PIXELS, 32'(row));
    phase_cnt++;
    @(negedge clk);
  endtask

  task automatic add_pixel(input rgba_t px);
    pixel_q.push_back(px);
    pushed_cnt++;
  endtask

  initial begin : stimulus
    int         rand_items;
    int         n;
    bit         pressed;
    logic [2:0] fmt;
    logic [10:0] row;
    rand_items = 0;
    pressed = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // partial alpha byte flushed at the end of a three-pixel row
    set_cfg(FMT_ALPHA1, 1'b0, 1'b0, 11'd3);
    add_pixel(32'h0000_0080);
    add_pixel(32'hFFFF_FF00);
    add_pixel(32'h1234_56FF);
    // four alpha2 samples fill one byte
    set_cfg(FMT_ALPHA2, 1'b0, 1'b0, 11'd2047);
    add_pixel(32'h0000_00C0);
    add_pixel(32'h0000_0040);
    add_pixel(32'h0000_00FF);
    add_pixel(32'h0000_0080);
    // sample width grows inside a byte
    set_cfg(FMT_ALPHA1, 1'b0, 1'b0, 11'd2047);
    add_pixel(32'h0000_00FF);
    add_pixel(32'h0000_007F);
    add_pixel(32'h0000_0080);
    set_cfg(FMT_ALPHA4, 1'b0, 1'b0, 11'd2047);
    add_pixel(32'h0000_00A5);
    add_pixel(32'h0000_005A);
    set_cfg(FMT_ALPHA8, 1'b0, 1'b0, 11'd2047);
    add_pixel(32'h0000_00C3);
    // pending alpha bits dropped when a colour pixel ends the row
    set_cfg(FMT_ALPHA2, 1'b0, 1'b0, 11'd2047);
    add_pixel(32'h0000_00FF);
    set_cfg(FMT_RGB332, 1'b0, 1'b0, 11'd12);
    add_pixel(32'h0000_0000);
    // colour formats
    set_cfg(FMT_RGB332, 1'b0, 1'b0, 11'd2047);
    add_pixel(32'h0000_0000);
    add_pixel(32'hFFFF_FFFF);
    set_cfg(FMT_RGB332, 1'b1, 1'b0, 11'd2047);
    add_pixel(32'hA55A_C33C);
    set_cfg(FMT_RGB565, 1'b0, 1'b0, 11'd2047);
    add_pixel(32'hF8FC_F880);
    add_pixel(32'h0703_0701);
    set_cfg(FMT_RGB565, 1'b1, 1'b1, 11'd2047);
    add_pixel(32'h1234_5678);
    set_cfg(FMT_ARGB8888, 1'b0, 1'b0, 11'd2047);
    add_pixel(32'h1122_3344);
    set_cfg(FMT_ARGB8888, 1'b1, 1'b0, 11'd2047);
    add_pixel(32'h8899_AABB);
    // unused format code, then a zero row length
    set_cfg(FMT_UNUSED, 1'b1, 1'b1, 11'd5);
    add_pixel(32'hDEAD_BEEF);
    set_cfg(FMT_ALPHA1, 1'b0, 1'b0, 11'd0);
    add_pixel(32'h0000_00FF);

    while (rand_items < RANDOM_PIXELS) begin
      if (!pressed && rand_items >= 100) begin
        // long output hold while argb8888 pixels keep coming
        set_cfg(FMT_ARGB8888, 1'($urandom_range(0, 1)), 1'b0, 11'd2047);
        hold_req <= 1'b1;
        repeat (40) add_pixel(rgba_t'($urandom()));
        rand_items += 40;
        pressed = 1'b1;
      end else begin
        fmt = ($urandom_range(0, 15) == 0) ? FMT_UNUSED : 3'($urandom_range(0, 6));
        case ($urandom_range(0, 9))
          0: row = 11'd0;
          1: row = 11'd2047;
          2: row = 11'($urandom_range(1, 2047));
          3: row = 11'd1;
          default: row = 11'($urandom_range(2, 9));
        endcase
        set_cfg(fmt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), row);
        n = $urandom_range(8, 30);
        repeat (n) add_pixel(rgba_t'($urandom()));
        rand_items += n;
      end
    end

    settle();
    $display("Sent %0d pixels, checked %0d bytes across %0d register settings.",
             accepted_cnt, bytes_seen, phase_cnt);
    $display("All seven formats plus the unused code, rows of 1 to 2048 pixels, one long stall.");
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/rgbpk_pkg.sv
hw/rtl/rgbpk_front.sv
hw/rtl/rgbpk_queue.sv
hw/rtl/rgbpk_back.sv
hw/rtl/rgba_pixel_format_packer.sv
test/testbench.sv
